// ===== design/hcs_pkg.sv =====
// shared types, codes and constants for the heater characterization sequencer
`timescale 1ns / 1ps
`default_nettype none

package hcs_pkg;

    // configuration port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY_LIMIT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_TIME    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_TIME   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COAST_TIME      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COAST_TIME = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TARGETS    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_TARGET    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_DONE_TEMP  = 4'd7;

    // request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_ABORT = 2'd2;
    localparam logic [1:0] REQ_FAULT = 2'd3;

    // phase codes
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_BASE   = 4'd1;
    localparam logic [3:0] PH_HEAT1  = 4'd2;
    localparam logic [3:0] PH_HEAT2  = 4'd4;
    localparam logic [3:0] PH_HEAT3  = 4'd6;
    localparam logic [3:0] PH_HEAT4  = 4'd8;
    localparam logic [3:0] PH_COAST4 = 4'd9;
    localparam logic [3:0] PH_FINAL  = 4'd10;
    localparam logic [3:0] PH_COOL   = 4'd11;
    localparam logic [3:0] PH_DONE   = 4'd12;
    localparam logic [3:0] PH_ABORT  = 4'd13;
    localparam logic [3:0] PH_ERROR  = 4'd14;

    // stop reasons
    localparam logic [2:0] RSN_NONE     = 3'd0;
    localparam logic [2:0] RSN_ABORT    = 3'd1;
    localparam logic [2:0] RSN_SENSOR   = 3'd2;
    localparam logic [2:0] RSN_INVALID  = 3'd3;
    localparam logic [2:0] RSN_OVERTEMP = 3'd4;
    localparam logic [2:0] RSN_TIMEOUT  = 3'd5;
    localparam logic [2:0] RSN_UNUSED   = 3'd7;

    // input transaction payload
    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        now_time;
        logic signed [15:0] temperature;
        logic               temp_valid;
        logic [2:0]         fault_code;
    } req_item_t;

    // result transaction payload
    typedef struct packed {
        logic [3:0]  phase;
        logic        heater_on;
        logic [2:0]  stop_reason;
        logic [31:0] run_elapsed;
    } res_item_t;

    // configuration register set
    typedef struct packed {
        logic signed [15:0] safety_limit;
        logic [31:0]        max_run_time;
        logic [31:0]        baseline_time;
        logic [31:0]        coast_time;
        logic [31:0]        last_coast_time;
        logic [63:0]        step_targets;
        logic signed [15:0] final_target;
        logic signed [15:0] cool_done_temp;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/heater_characterization_sequencer_unit.sv =====
// top level: request register, sequencer core, result register and configuration
// an accepted request is held in the request register, and its result is then captured in the result register
// throughput: one request per cycle, one result per request, limited only by res_ready
// the request register refills in the same cycle it hands over to the result register
// reset: asynchronous active low, clears both registers' valid flags and the held request,
// returns the sequencer to idle and loads the configuration registers with their defaults
`timescale 1ns / 1ps
`default_nettype none

module heater_characterization_sequencer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hcs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire hcs_pkg::req_item_t             req,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output hcs_pkg::res_item_t                  res
);
    import hcs_pkg::*;

    cfg_t      cfg;
    logic      req_valid_reg;
    req_item_t req_reg;
    logic      res_valid_reg;
    res_item_t res_reg;
    res_item_t res_next;
    logic      advance;

    hcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hcs_seq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (req_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // handshake
    assign advance   = req_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !req_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= '0;
        end
        else if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/hcs_cfg_regs.sv =====
// configuration register file for the heater characterization sequencer
`timescale 1ns / 1ps
`default_nettype none

module hcs_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [hcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hcs_pkg::CFG_DATA_W-1:0] cfg_data,
    output hcs_pkg::cfg_t                       cfg
);
    import hcs_pkg::*;

    cfg_t cfg_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.safety_limit    <= 16'sd4000;
            cfg_reg.max_run_time    <= 32'd1800000;
            cfg_reg.baseline_time   <= 32'd30000;
            cfg_reg.coast_time      <= 32'd60000;
            cfg_reg.last_coast_time <= 32'd90000;
            cfg_reg.step_targets    <= 64'd0;
            cfg_reg.final_target    <= 16'sd3840;
            cfg_reg.cool_done_temp  <= 16'sd800;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SAFETY_LIMIT:    cfg_reg.safety_limit    <= cfg_data[15:0];
                REG_MAX_RUN_TIME:    cfg_reg.max_run_time    <= cfg_data[31:0];
                REG_BASELINE_TIME:   cfg_reg.baseline_time   <= cfg_data[31:0];
                REG_COAST_TIME:      cfg_reg.coast_time      <= cfg_data[31:0];
                REG_LAST_COAST_TIME: cfg_reg.last_coast_time <= cfg_data[31:0];
                REG_STEP_TARGETS:    cfg_reg.step_targets    <= cfg_data;
                REG_FINAL_TARGET:    cfg_reg.final_target    <= cfg_data[15:0];
                REG_COOL_DONE_TEMP:  cfg_reg.cool_done_temp  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/hcs_seq_core.sv =====
// sequencer state and the per-transaction next-state and result logic
`timescale 1ns / 1ps
`default_nettype none

module hcs_seq_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire hcs_pkg::req_item_t item,
    input  wire hcs_pkg::cfg_t      cfg,
    output hcs_pkg::res_item_t      res
);
    import hcs_pkg::*;

    logic [3:0]  phase_reg,       phase_next;
    logic        heater_reg,      heater_next;
    logic [2:0]  reason_reg,      reason_next;
    logic [31:0] run_start_reg,   run_start_next;
    logic [31:0] phase_start_reg, phase_start_next;

    logic               running;
    logic [31:0]        run_time;
    logic [31:0]        in_phase;
    logic [1:0]         heat_idx;
    logic signed [15:0] heat_target;
    logic [31:0]        coast_dur;

    // shared terms
    always_comb
    begin
        running     = (phase_reg >= PH_BASE) && (phase_reg <= PH_COOL);
        run_time    = item.now_time - run_start_reg;
        in_phase    = item.now_time - phase_start_reg;
        heat_idx    = phase_reg[2:1] - 2'd1;
        heat_target = cfg.step_targets[{heat_idx, 4'b0000} +: 16];
        coast_dur   = (phase_reg == PH_COAST4) ? cfg.last_coast_time : cfg.coast_time;
    end

    // next state for one transaction
    always_comb
    begin
        phase_next       = phase_reg;
        heater_next      = heater_reg;
        reason_next      = reason_reg;
        run_start_next   = run_start_reg;
        phase_start_next = phase_start_reg;
        unique case (item.req_type)
            REQ_TICK:
            begin
                if (running)
                begin
                    priority if (!item.temp_valid)
                    begin
                        reason_next = RSN_INVALID;
                        heater_next = 1'b0;
                        phase_next  = PH_ERROR;
                    end
                    else if (item.temperature >= cfg.safety_limit)
                    begin
                        reason_next = RSN_OVERTEMP;
                        heater_next = 1'b0;
                        phase_next  = PH_ERROR;
                    end
                    else if (run_time >= cfg.max_run_time)
                    begin
                        reason_next = RSN_TIMEOUT;
                        heater_next = 1'b0;
                        phase_next  = PH_ERROR;
                    end
                    else if (phase_reg == PH_BASE)
                    begin
                        if (in_phase >= cfg.baseline_time)
                        begin
                            phase_next       = PH_HEAT1;
                            phase_start_next = item.now_time;
                            heater_next      = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_FINAL)
                    begin
                        if (item.temperature >= cfg.final_target)
                        begin
                            phase_next       = PH_COOL;
                            phase_start_next = item.now_time;
                            heater_next      = 1'b0;
                        end
                    end
                    else if (phase_reg == PH_COOL)
                    begin
                        if (item.temperature <= cfg.cool_done_temp)
                        begin
                            phase_next       = PH_DONE;
                            phase_start_next = item.now_time;
                            heater_next      = 1'b0;
                        end
                    end
                    else if (!phase_reg[0])
                    begin
                        // heat step, leave once the step target is reached
                        if (item.temperature >= heat_target)
                        begin
                            phase_next       = phase_reg + 4'd1;
                            phase_start_next = item.now_time;
                            heater_next      = 1'b0;
                        end
                    end
                    else
                    begin
                        // coast, leave after its duration
                        if (in_phase >= coast_dur)
                        begin
                            phase_next       = phase_reg + 4'd1;
                            phase_start_next = item.now_time;
                            heater_next      = 1'b1;
                        end
                    end
                end
            end
            REQ_START:
            begin
                run_start_next   = item.now_time;
                reason_next      = RSN_NONE;
                phase_next       = PH_BASE;
                phase_start_next = item.now_time;
                heater_next      = 1'b0;
            end
            REQ_ABORT:
            begin
                reason_next = RSN_ABORT;
                heater_next = 1'b0;
                phase_next  = PH_ABORT;
            end
            REQ_FAULT:
            begin
                reason_next = (item.fault_code == RSN_UNUSED) ? RSN_SENSOR : item.fault_code;
                heater_next = 1'b0;
                phase_next  = PH_ERROR;
            end
        endcase
    end

    // result seen after this transaction
    always_comb
    begin
        res.phase       = phase_next;
        res.heater_on   = heater_next;
        res.stop_reason = reason_next;
        res.run_elapsed = (phase_next == PH_IDLE) ? 32'd0 : item.now_time - run_start_next;
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            heater_reg      <= 1'b0;
            reason_reg      <= RSN_NONE;
            run_start_reg   <= 32'd0;
            phase_start_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            heater_reg      <= heater_next;
            reason_reg      <= reason_next;
            run_start_reg   <= run_start_next;
            phase_start_reg <= phase_start_next;
        end
    end

    // heater only driven in heat phases
    assert property (@(posedge clk) disable iff (!rst_n)
        heater_reg |-> (phase_reg == PH_HEAT1 || phase_reg == PH_HEAT2 ||
                        phase_reg == PH_HEAT3 || phase_reg == PH_HEAT4 ||
                        phase_reg == PH_FINAL))
        else $error("heater on outside a heat phase");

    // idle carries no stop reason
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (reason_reg == RSN_NONE && !heater_reg))
        else $error("idle with reason or heater set");

    // aborted always reports the abort reason
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ABORT) |-> (reason_reg == RSN_ABORT))
        else $error("aborted without abort reason");

    // state moves only on a processed transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(run_start_reg) && $stable(reason_reg)))
        else $error("state changed without a transaction");

endmodule

`default_nettype wire

// ===== dv/tb_heater_characterization_sequencer_unit.sv =====
// testbench for the heater characterization sequencer: directed and random requests checked by a phase predictor
`timescale 1ns / 1ps

module tb_heater_characterization_sequencer_unit;
    import hcs_pkg::*;

    // reason code with no name in the package
    localparam logic [2:0] RSN_UPDATE = 3'd6;
    // register indexes from here up are not decoded
    localparam int FIRST_UNUSED_REG = 8;
    localparam int LAST_UNUSED_REG  = 15;
    localparam int SEGMENT_COUNT    = 7;
    localparam int SEGMENT_ITEMS    = 205;
    localparam int HOLD_CYCLES      = 80;

    // phase predictor and store of expected status transactions
    class sequencer_scoreboard;
        cfg_t        regs;
        logic [3:0]  phase_q;
        logic        heater_q;
        logic [2:0]  reason_q;
        logic [31:0] run_start_q;
        logic [31:0] phase_start_q;
        res_item_t   expected_status_q[$];
        int          mismatch_count;

        function new();
            regs.safety_limit    = 16'sd4000;
            regs.max_run_time    = 32'd1800000;
            regs.baseline_time   = 32'd30000;
            regs.coast_time      = 32'd60000;
            regs.last_coast_time = 32'd90000;
            regs.step_targets    = 64'd0;
            regs.final_target    = 16'sd3840;
            regs.cool_done_temp  = 16'sd800;
            phase_q              = PH_IDLE;
            heater_q             = 1'b0;
            reason_q             = RSN_NONE;
            run_start_q          = 32'd0;
            phase_start_q        = 32'd0;
            mismatch_count       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SAFETY_LIMIT:    regs.safety_limit    = data[15:0];
                REG_MAX_RUN_TIME:    regs.max_run_time    = data[31:0];
                REG_BASELINE_TIME:   regs.baseline_time   = data[31:0];
                REG_COAST_TIME:      regs.coast_time      = data[31:0];
                REG_LAST_COAST_TIME: regs.last_coast_time = data[31:0];
                REG_STEP_TARGETS:    regs.step_targets    = data;
                REG_FINAL_TARGET:    regs.final_target    = data[15:0];
                REG_COOL_DONE_TEMP:  regs.cool_done_temp  = data[15:0];
                default: ;
            endcase
        endfunction

        function void enter_phase(logic [3:0] ph, logic [31:0] now, logic heat);
            phase_q       = ph;
            phase_start_q = now;
            heater_q      = heat;
        endfunction

        function void stop_with(logic [3:0] ph, logic [2:0] why);
            reason_q = why;
            heater_q = 1'b0;
            phase_q  = ph;
        endfunction

        // safety checks first, then the phase step
        function void advance_on_tick(logic [31:0] now, logic signed [15:0] t, logic ok);
            logic [31:0]        run_span;
            logic [31:0]        in_phase;
            logic [31:0]        hold_time;
            logic signed [15:0] goal;
            int                 k;
            if (phase_q < PH_BASE || phase_q > PH_COOL)
                return;
            run_span = now - run_start_q;
            in_phase = now - phase_start_q;
            goal     = regs.safety_limit;
            if (!ok)
                stop_with(PH_ERROR, RSN_INVALID);
            else if (t >= goal)
                stop_with(PH_ERROR, RSN_OVERTEMP);
            else if (run_span >= regs.max_run_time)
                stop_with(PH_ERROR, RSN_TIMEOUT);
            else if (phase_q == PH_BASE)
            begin
                if (in_phase >= regs.baseline_time)
                    enter_phase(PH_HEAT1, now, 1'b1);
            end
            else if (phase_q == PH_FINAL)
            begin
                goal = regs.final_target;
                if (t >= goal)
                    enter_phase(PH_COOL, now, 1'b0);
            end
            else if (phase_q == PH_COOL)
            begin
                goal = regs.cool_done_temp;
                if (t <= goal)
                    enter_phase(PH_DONE, now, 1'b0);
            end
            else if (!phase_q[0])
            begin
                // heat steps, target k in bits 16k+15..16k
                k    = (int'(phase_q) - int'(PH_HEAT1)) / 2;
                goal = regs.step_targets[16*k +: 16];
                if (t >= goal)
                    enter_phase(phase_q + 4'd1, now, 1'b0);
            end
            else
            begin
                // coast phases, the fourth one has its own duration
                hold_time = (phase_q == PH_COAST4) ? regs.last_coast_time : regs.coast_time;
                if (in_phase >= hold_time)
                    enter_phase(phase_q + 4'd1, now, 1'b1);
            end
        endfunction

        function void note_request(req_item_t item);
            res_item_t want;
            case (item.req_type)
                REQ_TICK:
                    advance_on_tick(item.now_time, item.temperature, item.temp_valid);
                REQ_START:
                begin
                    run_start_q = item.now_time;
                    reason_q    = RSN_NONE;
                    enter_phase(PH_BASE, item.now_time, 1'b0);
                end
                REQ_ABORT:
                    stop_with(PH_ABORT, RSN_ABORT);
                REQ_FAULT:
                    stop_with(PH_ERROR,
                              (item.fault_code == RSN_UNUSED) ? RSN_SENSOR : item.fault_code);
                default: ;
            endcase
            want.phase       = phase_q;
            want.heater_on   = heater_q;
            want.stop_reason = reason_q;
            want.run_elapsed = (phase_q == PH_IDLE) ? 32'd0 : item.now_time - run_start_q;
            expected_status_q.push_back(want);
        endfunction

        function void check_status(res_item_t got);
            res_item_t want;
            if (expected_status_q.size() == 0)
            begin
                $error("result transaction with nothing expected, phase %0d", got.phase);
                mismatch_count++;
                return;
            end
            want = expected_status_q.pop_front();
            if (got.phase !== want.phase)
            begin
                $error("phase expected %0d got %0d", want.phase, got.phase);
                mismatch_count++;
            end
            if (got.heater_on !== want.heater_on)
            begin
                $error("heater_on expected %0d got %0d", want.heater_on, got.heater_on);
                mismatch_count++;
            end
            if (got.stop_reason !== want.stop_reason)
            begin
                $error("stop_reason expected %0d got %0d", want.stop_reason, got.stop_reason);
                mismatch_count++;
            end
            if (got.run_elapsed !== want.run_elapsed)
            begin
                $error("run_elapsed expected %0h got %0h", want.run_elapsed, got.run_elapsed);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  req_valid;
    logic                  req_ready;
    req_item_t             req;
    logic                  res_valid;
    logic                  res_ready;
    res_item_t             res;

    int                    send_idle_pct;
    int                    recv_idle_pct;
    bit                    hold_req;
    logic [31:0]           clock_ms;
    req_item_t             directed_q[$];
    sequencer_scoreboard   sb;

    heater_characterization_sequencer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // transaction monitor: config, then request, then result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (req_valid && req_ready)
                sb.note_request(req);
            if (res_valid && res_ready)
                sb.check_status(res);
        end
    end

    // result receiver with random stalls and a long hold-off on demand
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready = 1'b0;
            end
            else
                res_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[heater_characterization_sequencer_unit] ERROR");
        $finish;
    end

    function automatic req_item_t make_req(logic [1:0] kind, logic [31:0] now,
                                           logic signed [15:0] temp, logic ok,
                                           logic [2:0] code);
        req_item_t item;
        item.req_type    = kind;
        item.now_time    = now;
        item.temperature = temp;
        item.temp_valid  = ok;
        item.fault_code  = code;
        return item;
    endfunction

    // temperatures clustered near cooldown end, near the heat targets, or anywhere
    function automatic logic signed [15:0] pick_temperature();
        logic signed [15:0] s;
        int                 hot;
        int                 ceil_v;
        int                 cool;
        int                 roll;
        int                 v;
        s      = sb.regs.safety_limit;
        ceil_v = int'(s) - 1;
        s      = sb.regs.final_target;
        hot    = int'(s);
        for (int k = 0; k < 4; k++)
        begin
            s = sb.regs.step_targets[16*k +: 16];
            if (int'(s) > hot)
                hot = int'(s);
        end
        if (hot > ceil_v)
            hot = ceil_v;
        s    = sb.regs.cool_done_temp;
        cool = int'(s);
        roll = $urandom_range(99);
        if (roll < 40)
            v = cool - int'($urandom_range(64));
        else if (roll < 85)
            v = hot + int'($urandom_range(ceil_v - hot));
        else if (roll < 97)
            v = (ceil_v > cool) ? cool + int'($urandom_range(ceil_v - cool)) : cool;
        else
            v = int'($urandom_range(65535)) - 32768;
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v[15:0];
    endfunction

    // mostly well-formed runs, some broken runs and noise
    function automatic req_item_t next_random_item();
        int   roll;
        logic ended;
        ended = (sb.phase_q == PH_IDLE) || (sb.phase_q >= PH_DONE);
        roll  = $urandom_range(99);
        clock_ms += 32'($urandom_range(40));
        if (roll < 8)
            return make_req(2'($urandom_range(3)), $urandom(), 16'($urandom_range(65535)),
                            1'($urandom_range(1)), 3'($urandom_range(7)));
        if ((ended && roll >= 25) || (!ended && roll < 11))
        begin
            // some runs start just below the counter wrap
            if ($urandom_range(99) < 15)
                clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(300));
            return make_req(REQ_START, clock_ms, pick_temperature(), 1'b1, RSN_NONE);
        end
        if (roll < 14)
            return make_req(REQ_TICK, clock_ms, pick_temperature(), 1'b0, RSN_NONE);
        if (roll < 17)
            return make_req(REQ_ABORT, clock_ms, pick_temperature(), 1'b1, RSN_NONE);
        if (roll < 20)
            return make_req(REQ_FAULT, clock_ms, pick_temperature(), 1'b1,
                            3'($urandom_range(7)));
        return make_req(REQ_TICK, clock_ms, pick_temperature(), 1'b1, RSN_NONE);
    endfunction

    // offer one request transaction, with random idle cycles ahead of it
    task automatic send_item(req_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req       = item;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // all status transactions back, plus the pipeline depth
    task automatic wait_drained();
        while (sb.expected_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // register set for one random segment, unused bits of the data filled with noise
    task automatic apply_setting(int seg);
        cfg_t next;
        next.safety_limit    = 16'(3000 + $urandom_range(1000));
        next.max_run_time    = (seg == 2) ? 32'(200 + $urandom_range(400))
                                          : 32'(3000 + $urandom_range(5000));
        next.baseline_time   = 32'($urandom_range(60));
        next.coast_time      = 32'($urandom_range(60));
        next.last_coast_time = 32'($urandom_range(100));
        for (int k = 0; k < 4; k++)
            next.step_targets[16*k +: 16] = 16'(500 + $urandom_range(2300));
        next.final_target    = 16'(500 + $urandom_range(2300));
        next.cool_done_temp  = 16'($urandom_range(400));
        case (seg)
            1:
            begin
                // every valid tick below the limit moves one phase on
                next.safety_limit    = 16'sh7FFF;
                next.max_run_time    = 32'hFFFF_FFFF;
                next.baseline_time   = 32'd0;
                next.coast_time      = 32'd0;
                next.last_coast_time = 32'd0;
                next.step_targets    = {4{16'h8000}};
                next.final_target    = 16'sh8000;
                next.cool_done_temp  = 16'sh7FFF;
            end
            3:
            begin
                // zero run time limit, the step phases never advance
                next.safety_limit    = 16'sh7FFF;
                next.max_run_time    = 32'd0;
                next.baseline_time   = 32'hFFFF_FFFF;
                next.coast_time      = 32'hFFFF_FFFF;
                next.last_coast_time = 32'hFFFF_FFFF;
                next.step_targets    = {4{16'h7FFF}};
                next.final_target    = 16'sh7FFF;
                next.cool_done_temp  = 16'sh8000;
            end
            6:
            begin
                // every valid reading is over the limit
                next.safety_limit = 16'sh8000;
                next.max_run_time = 32'd1;
            end
            default: ;
        endcase
        if (seg == 0)
            write_register(CFG_IDX_W'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)),
                           {$urandom(), $urandom()});
        write_register(REG_SAFETY_LIMIT,    {$urandom(), 16'($urandom()), next.safety_limit});
        write_register(REG_MAX_RUN_TIME,    {$urandom(), next.max_run_time});
        write_register(REG_BASELINE_TIME,   {$urandom(), next.baseline_time});
        write_register(REG_COAST_TIME,      {$urandom(), next.coast_time});
        write_register(REG_LAST_COAST_TIME, {$urandom(), next.last_coast_time});
        write_register(REG_STEP_TARGETS,    next.step_targets);
        write_register(REG_FINAL_TARGET,    {$urandom(), 16'($urandom()), next.final_target});
        write_register(REG_COOL_DONE_TEMP,  {$urandom(), 16'($urandom()), next.cool_done_temp});
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        sb            = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        req_valid     = 1'b0;
        req           = '0;
        hold_req      = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 58;
        clock_ms      = 32'd0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part on reset register values
        directed_q.push_back(make_req(REQ_TICK, 32'd123, 16'sd100, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFFF, 16'sh8000, 1'b0, RSN_UNUSED));
        directed_q.push_back(make_req(REQ_ABORT, 32'd500, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_FAULT, 32'd600, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_FAULT, 32'd700, 16'sd0, 1'b1, RSN_UNUSED));
        directed_q.push_back(make_req(REQ_FAULT, 32'd800, 16'sd0, 1'b1, RSN_UPDATE));
        directed_q.push_back(make_req(REQ_START, 32'hFFFF_FF00, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FF0A, 16'sd200, 1'b0, RSN_NONE));
        directed_q.push_back(make_req(REQ_START, 32'd1000, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'd1005, 16'sh7FFF, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_START, 32'd5000, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'd1805000, 16'sd100, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_START, 32'hFFFF_FFF0, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFF0 + 32'd29999, 16'sh8000, 1'b1,
                                      RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFF0 + 32'd30000, 16'sh8000, 1'b1,
                                      RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFF0 + 32'd30001, -16'sd1, 1'b1,
                                      RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFF0 + 32'd30001, 16'sd0, 1'b1,
                                      RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'hFFFF_FFF0 + 32'd30002, 16'sd3999, 1'b1,
                                      RSN_NONE));
        directed_q.push_back(make_req(REQ_START, 32'd70000, 16'sd0, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'd70001, 16'sd4000, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'd70002, 16'sd10, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_ABORT, 32'd70003, 16'sd10, 1'b1, RSN_NONE));
        directed_q.push_back(make_req(REQ_TICK, 32'd70004, 16'sd10, 1'b1, RSN_NONE));
        foreach (directed_q[i])
            send_item(directed_q[i]);
        req_valid = 1'b0;

        // random segments, each with its own register set, in three idle patterns
        for (int seg = 0; seg < SEGMENT_COUNT; seg++)
        begin
            wait_drained();
            if (seg < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 58;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(seg);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                // receiver holds off while requests keep coming
                if (seg == 4 && n == 60)
                    hold_req = 1'b1;
                send_item(next_random_item());
            end
            req_valid = 1'b0;
        end

        wait_drained();
        if (sb.mismatch_count == 0)
            $display("[heater_characterization_sequencer_unit] OK");
        else
            $display("[heater_characterization_sequencer_unit] ERROR");
        $finish;
    end

endmodule
